[rtl/msam_pkg.sv]
// Shared types, constants and defaults for the multi-source audio mixer.
package msam_pkg;

    localparam int DEF_NUM_SOURCES = 16;
    localparam int DEF_CLIP_FRAMES = 1024;
    localparam int CHANNELS        = 2;
    localparam int CH_LEFT         = 0;
    localparam int CH_RIGHT        = 1;

    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = CHANNELS * SAMPLE_W;
    localparam int SRC_IN_W   = 4;
    localparam int ADDR_IN_W  = 10;
    localparam int LEN_IN_W   = 11;
    localparam int MAX_LEN_IN = (1 << LEN_IN_W) - 1;
    localparam int GAIN_W     = 17;
    localparam int GAIN_FRAC  = 16;
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;

    localparam logic [GAIN_W-1:0]          GAIN_UNITY = GAIN_W'(1 << GAIN_FRAC);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_PLAY  = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_MIX   = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type              req_type;
        logic [SRC_IN_W-1:0]    source_index;
        logic [ADDR_IN_W-1:0]   frame_addr;
        t_sample                sample_left;
        t_sample                sample_right;
        logic [LEN_IN_W-1:0]    clip_length;
        logic                   loop_enable;
        logic [GAIN_W-1:0]      volume;
    } t_req;

    typedef struct packed {
        t_sample out_left;
        t_sample out_right;
    } t_mix;

    typedef struct packed {
        logic clear;
        logic mul_en;
    } t_dp_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_DRAIN
    } t_state;

endpackage

[rtl/msam_stream_if.sv]
// Valid/ready stream interface carrying one payload per transaction.
interface msam_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/multi_source_audio_mixer.sv]
// Top level of the multi-source stereo audio mixer: request sequencer and source walk.
// Write, play and stop requests produce no result.
// A mix request holds off further requests while the sequencer walks every source, drains
// the pipeline and waits for the output register to be free; the result is registered
// on the return to idle. The walk reads the source-state memory one entry per cycle.
// Reset clears the sequencer, the pipeline and the source valid bits; clip memory is
// left undefined and gets no clearing pass.
module multi_source_audio_mixer #(
    parameter int NUM_SOURCES = msam_pkg::DEF_NUM_SOURCES,
    parameter int CLIP_FRAMES = msam_pkg::DEF_CLIP_FRAMES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    msam_stream_if.sink   i_req,
    msam_stream_if.source o_mix
);
    import msam_pkg::*;

    // Clip lengths are bounded both by the clip size and by the request field width.
    localparam int MAX_LEN = (CLIP_FRAMES < MAX_LEN_IN) ? CLIP_FRAMES : MAX_LEN_IN;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int FR_W    = $clog2(CLIP_FRAMES);
    localparam int SRC_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int CA_W    = $clog2(NUM_SOURCES * CLIP_FRAMES);

    typedef struct packed {
        logic              playing;
        logic              loop_en;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  len;
        logic [GAIN_W-1:0] gain;
    } t_src_ent;

    localparam int ENT_W = $bits(t_src_ent);

    // Sequencer state and the three-stage source pipeline.
    t_state            r_state, n_state;
    logic [SRC_W-1:0]  r_src;
    logic              r_v1;
    logic [SRC_W-1:0]  r_s1;
    logic              r_v2;
    logic [GAIN_W-1:0] r_gain;
    logic              r_ov;
    t_mix              r_out;

    logic req_ready, issue, mix_start, load, drain_done, accept;

    // Memory ports.
    logic             cm_we;
    logic [CA_W-1:0]  cm_waddr, cm_raddr;
    logic [FRAME_W-1:0] cm_rdata;
    logic             sm_we;
    logic [SRC_W-1:0] sm_waddr;
    t_src_ent         sm_wdata;
    logic [ENT_W-1:0] sm_rdata;

    // Datapath.
    t_dp_ctl dp_ctl;
    t_sample dp_smp [CHANNELS];
    t_sample dp_acc [CHANNELS];
    logic    dp_busy;

    // Request decode.
    t_req             rq;
    logic             src_ok, addr_ok;
    logic [POS_W-1:0] len_sat;
    logic [GAIN_W-1:0] gain_sat;

    // Stage one: the state entry of one source has just been read.
    t_src_ent         ent;
    logic             wrap, resume, use_src, stop_src;
    logic [POS_W-1:0] pos_eff;

    assign rq       = i_req.data;
    assign accept   = i_req.valid && req_ready;
    assign src_ok   = int'(rq.source_index) < NUM_SOURCES;
    assign addr_ok  = int'(rq.frame_addr) < CLIP_FRAMES;
    assign len_sat  = (int'(rq.clip_length) > CLIP_FRAMES) ? POS_W'(CLIP_FRAMES)
                                                           : POS_W'(rq.clip_length);
    assign gain_sat = (rq.volume > GAIN_UNITY) ? GAIN_UNITY : rq.volume;

    // A source at the end of its clip rewinds only when it loops and has a nonzero length.
    assign ent      = t_src_ent'(sm_rdata);
    assign wrap     = ent.pos >= ent.len;
    assign resume   = ent.loop_en && (ent.len != '0);
    assign use_src  = r_v1 && ent.playing && (!wrap || resume);
    assign stop_src = r_v1 && ent.playing && wrap && !resume;
    assign pos_eff  = wrap ? '0 : ent.pos;

    assign drain_done = !r_v1 && !r_v2 && !dp_busy;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (rq.req_type == REQ_MIX)) begin
                    n_state = ST_MIX;
                end
            end
            ST_MIX: begin
                if (r_src == SRC_W'(NUM_SOURCES - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_done && (!r_ov || o_mix.ready)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        req_ready = 1'b0;
        issue     = 1'b0;
        mix_start = 1'b0;
        load      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                req_ready = 1'b1;
                mix_start = accept && (rq.req_type == REQ_MIX);
            end
            ST_MIX: begin
                issue = 1'b1;
            end
            ST_DRAIN: begin
                load = drain_done && (!r_ov || o_mix.ready);
            end
            default: begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign i_req.ready = req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_src   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mix_start) begin
                r_src <= '0;
            end else if (issue) begin
                r_src <= r_src + SRC_W'(1);
            end
            r_v1 <= issue;
            r_v2 <= use_src;
            if (load) begin
                r_ov <= 1'b1;
            end else if (o_mix.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1 <= r_src;
        end
        if (use_src) begin
            r_gain <= ent.gain;
        end
        if (load) begin
            r_out.out_left  <= dp_acc[CH_LEFT];
            r_out.out_right <= dp_acc[CH_RIGHT];
        end
    end

    assign o_mix.valid = r_ov;
    assign o_mix.data  = r_out;

    // Source-state write port: play and stop while idle, write-back during the walk.
    always_comb begin
        sm_we    = 1'b0;
        sm_waddr = r_s1;
        sm_wdata = '0;
        if (accept && src_ok && (rq.req_type == REQ_PLAY)) begin
            sm_we    = 1'b1;
            sm_waddr = SRC_W'(rq.source_index);
            sm_wdata = '{playing: 1'b1, loop_en: rq.loop_enable, pos: '0,
                         len: len_sat, gain: gain_sat};
        end else if (accept && src_ok && (rq.req_type == REQ_STOP)) begin
            // A stopped source is only ever revived by play, which rewrites every field.
            sm_we    = 1'b1;
            sm_waddr = SRC_W'(rq.source_index);
        end else if (use_src) begin
            sm_we       = 1'b1;
            sm_wdata    = ent;
            sm_wdata.pos = pos_eff + POS_W'(1);
        end else if (stop_src) begin
            sm_we = 1'b1;
        end
    end

    assign cm_we    = accept && src_ok && addr_ok && (rq.req_type == REQ_WRITE);
    assign cm_waddr = CA_W'(CA_W'(rq.source_index) * CA_W'(CLIP_FRAMES))
                      + CA_W'(rq.frame_addr);
    assign cm_raddr = CA_W'(CA_W'(r_s1) * CA_W'(CLIP_FRAMES)) + CA_W'(FR_W'(pos_eff));

    msam_src_mem #(
        .NUM_SOURCES (NUM_SOURCES),
        .SRC_W       (SRC_W),
        .ENT_W       (ENT_W)
    ) u_src_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (sm_we),
        .i_waddr (sm_waddr),
        .i_wdata (sm_wdata),
        .i_raddr (r_src),
        .o_rdata (sm_rdata)
    );

    msam_clip_mem #(
        .DEPTH (NUM_SOURCES * CLIP_FRAMES),
        .AW    (CA_W)
    ) u_clip_mem (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (cm_waddr),
        .i_wdata ({rq.sample_left, rq.sample_right}),
        .i_raddr (cm_raddr),
        .o_rdata (cm_rdata)
    );

    // Clip data and gain meet at the multiplier in the cycle after the clip read.
    assign dp_smp[CH_LEFT]  = cm_rdata[FRAME_W-1 -: SAMPLE_W];
    assign dp_smp[CH_RIGHT] = cm_rdata[SAMPLE_W-1:0];
    assign dp_ctl.clear     = mix_start;
    assign dp_ctl.mul_en    = r_v2;

    msam_mix_dp u_mix_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dp_ctl),
        .i_gain  (r_gain),
        .i_smp   (dp_smp),
        .o_acc   (dp_acc),
        .o_busy  (dp_busy)
    );

`ifndef SYNTHESIS
    // The write-back of one source never lands on the entry being read for the next.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && sm_we) |-> (sm_waddr != r_src))
        else $error("source state write-back collides with the walk read");

    // An accepted mix request always starts the source walk.
    a_mix_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (rq.req_type == REQ_MIX)) |=> (r_state == ST_MIX) && (r_src == '0))
        else $error("mix request did not start the source walk");

    // No pipeline stage is busy while new requests are taken.
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_v1 && !r_v2 && !dp_busy))
        else $error("source pipeline busy while idle");
`endif

endmodule

[rtl/msam_clip_mem.sv]
// Stereo clip store: one write port, one read port with registered data.
module msam_clip_mem #(
    parameter int DEPTH = msam_pkg::DEF_NUM_SOURCES * msam_pkg::DEF_CLIP_FRAMES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [msam_pkg::FRAME_W-1:0] i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic [msam_pkg::FRAME_W-1:0] o_rdata
);
    import msam_pkg::*;

    logic [FRAME_W-1:0] r_mem [DEPTH];
    logic [FRAME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/msam_src_mem.sv]
// Per-source playback state memory; entries without a valid bit read as zero.
module msam_src_mem #(
    parameter int NUM_SOURCES = msam_pkg::DEF_NUM_SOURCES,
    parameter int SRC_W       = 4,
    parameter int ENT_W       = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [SRC_W-1:0] i_waddr,
    input  logic [ENT_W-1:0] i_wdata,
    input  logic [SRC_W-1:0] i_raddr,
    output logic [ENT_W-1:0] o_rdata
);
    logic [ENT_W-1:0]       r_mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] r_vld;
    logic [ENT_W-1:0]       r_rdata;
    logic                   r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;
endmodule

[rtl/msam_mix_dp.sv]
// Gain multiply, truncation toward zero and saturating accumulation per channel.
module msam_mix_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  msam_pkg::t_dp_ctl             i_ctl,
    input  logic [msam_pkg::GAIN_W-1:0]   i_gain,
    input  msam_pkg::t_sample             i_smp [msam_pkg::CHANNELS],
    output msam_pkg::t_sample             o_acc [msam_pkg::CHANNELS],
    output logic                          o_busy
);
    import msam_pkg::*;

    localparam int SUM_W = SAMPLE_W + 2;

    logic signed [PROD_W-1:0] r_prod [CHANNELS];
    logic                     r_mv;
    t_sample                  r_acc  [CHANNELS];
    logic signed [PROD_W-1:0] q      [CHANNELS];
    logic signed [SUM_W-1:0]  sum    [CHANNELS];
    t_sample                  n_acc  [CHANNELS];

    // Products land in a register before the accumulate stage.
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (i_ctl.mul_en) begin
                r_prod[c] <= PROD_W'(i_smp[c] * $signed({1'b0, i_gain}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= i_ctl.mul_en;
        end
    end

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            // Arithmetic shift floors; negative values with a fraction step back up.
            q[c] = r_prod[c] >>> GAIN_FRAC;
            if (r_prod[c][PROD_W-1] && (r_prod[c][GAIN_FRAC-1:0] != '0)) begin
                q[c] = q[c] + PROD_W'(1);
            end
            sum[c] = SUM_W'(r_acc[c]) + SUM_W'(q[c]);
            if (sum[c] > SUM_W'(SAMPLE_MAX)) begin
                n_acc[c] = SAMPLE_MAX;
            end else if (sum[c] < SUM_W'(SAMPLE_MIN)) begin
                n_acc[c] = SAMPLE_MIN;
            end else begin
                n_acc[c] = sum[c][SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (i_ctl.clear) begin
                r_acc[c] <= '0;
            end else if (r_mv) begin
                r_acc[c] <= n_acc[c];
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_mv;
endmodule

[sim/msam_mix_checker.sv]
// Checker for the audio mixer: watches both channels, predicts every mixed frame and compares.
module msam_mix_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_ready,
    input  msam_pkg::t_req   i_req_data,
    input  logic             i_mix_valid,
    input  logic             i_mix_ready,
    input  msam_pkg::t_mix   i_mix_data,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import msam_pkg::*;

    localparam int NSRC = DEF_NUM_SOURCES;
    localparam int NFRM = DEF_CLIP_FRAMES;

    // Clip store and per-source playback state of the predictor.
    t_sample              clip_left  [NSRC*NFRM];
    t_sample              clip_right [NSRC*NFRM];
    logic                 src_on     [NSRC];
    logic                 src_loop   [NSRC];
    logic [LEN_IN_W-1:0]  src_pos    [NSRC];
    logic [LEN_IN_W-1:0]  src_len    [NSRC];
    logic [GAIN_W-1:0]    src_gain   [NSRC];

    t_mix expected_frames[$];

    initial begin
        for (int i = 0; i < NSRC*NFRM; i++) begin
            clip_left[i]  = '0;
            clip_right[i] = '0;
        end
    end

    // Q16 scaling, truncated toward zero.
    function automatic longint scale_sample(t_sample smp, logic [GAIN_W-1:0] g);
        longint prod;
        prod = longint'(smp) * longint'(g);
        return prod / longint'(GAIN_UNITY);
    endfunction

    function automatic longint clamp_sum(longint v);
        if (v < longint'(SAMPLE_MIN)) return longint'(SAMPLE_MIN);
        if (v > longint'(SAMPLE_MAX)) return longint'(SAMPLE_MAX);
        return v;
    endfunction

    task automatic apply_request(input t_req r);
        int     slot;
        int     s;
        longint acc_l;
        longint acc_r;
        t_mix   frame;
        slot = int'(r.source_index) * NFRM + int'(r.frame_addr);
        case (r.req_type)
            REQ_WRITE: begin
                clip_left[slot]  = r.sample_left;
                clip_right[slot] = r.sample_right;
            end
            REQ_PLAY: begin
                s = int'(r.source_index);
                src_on[s]   = 1'b1;
                src_pos[s]  = '0;
                src_len[s]  = (r.clip_length > LEN_IN_W'(NFRM)) ? LEN_IN_W'(NFRM)
                                                                : r.clip_length;
                src_loop[s] = r.loop_enable;
                src_gain[s] = (r.volume > GAIN_UNITY) ? GAIN_UNITY : r.volume;
            end
            REQ_STOP: begin
                src_on[int'(r.source_index)] = 1'b0;
            end
            default: begin
                acc_l = 0;
                acc_r = 0;
                for (s = 0; s < NSRC; s++) begin
                    if (!src_on[s]) continue;
                    if (src_pos[s] >= src_len[s]) begin
                        if (src_loop[s] && src_len[s] != '0) begin
                            src_pos[s] = '0;
                        end else begin
                            src_on[s] = 1'b0;
                            continue;
                        end
                    end
                    slot  = s * NFRM + int'(src_pos[s]);
                    acc_l = clamp_sum(acc_l + scale_sample(clip_left[slot], src_gain[s]));
                    acc_r = clamp_sum(acc_r + scale_sample(clip_right[slot], src_gain[s]));
                    src_pos[s] = src_pos[s] + 1'b1;
                end
                frame.out_left  = t_sample'(acc_l);
                frame.out_right = t_sample'(acc_r);
                expected_frames.push_back(frame);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSRC; s++) begin
                src_on[s]   = 1'b0;
                src_loop[s] = 1'b0;
                src_pos[s]  = '0;
                src_len[s]  = '0;
                src_gain[s] = '0;
            end
            expected_frames.delete();
            o_fail_count = 0;
        end else begin
            if (i_mix_valid && i_mix_ready) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected mixed frame L=%0d R=%0d", $time,
                             i_mix_data.out_left, i_mix_data.out_right);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    if (i_mix_data.out_left !== expected_frames[0].out_left) begin
                        $display("%0t: out_left mismatch, expected %0d actual %0d", $time,
                                 expected_frames[0].out_left, i_mix_data.out_left);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_mix_data.out_right !== expected_frames[0].out_right) begin
                        $display("%0t: out_right mismatch, expected %0d actual %0d", $time,
                                 expected_frames[0].out_right, i_mix_data.out_right);
                        o_fail_count = o_fail_count + 1;
                    end
                    void'(expected_frames.pop_front());
                end
            end
            if (i_req_valid && i_req_ready) begin
                apply_request(i_req_data);
            end
        end
        o_pending = expected_frames.size();
    end

endmodule

[sim/tb.sv]
// Testbench top for the audio mixer: clock, reset, request stimulus, output stalls and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import msam_pkg::*;

    localparam int NSRC = DEF_NUM_SOURCES;
    localparam int NFRM = DEF_CLIP_FRAMES;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    msam_stream_if #(.T(t_req)) req_if ();
    msam_stream_if #(.T(t_mix)) mix_if ();

    int chk_fails;
    int chk_pending;

    multi_source_audio_mixer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_mix   (mix_if)
    );

    // The checker sees every transaction on both channels and keeps its own prediction.
    msam_mix_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_if.valid),
        .i_req_ready  (req_if.ready),
        .i_req_data   (req_if.data),
        .i_mix_valid  (mix_if.valid),
        .i_mix_ready  (mix_if.ready),
        .i_mix_data   (mix_if.data),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending)
    );

    // 12 ns clock period.
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard limit on the run, several times the slowest legal run.
    initial begin
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // The stimulus side keeps a light copy of the playback state. It is used only to know
    // which clip frame each playing source reads at the next mix, so that a frame that was
    // never written is filled in first and no read of undefined clip memory is caused.
    bit frame_written [NSRC][NFRM];
    bit plan_on       [NSRC];
    bit plan_loop     [NSRC];
    int plan_pos      [NSRC];
    int plan_len      [NSRC];

    int items_sent = 0;
    int burst_left = 4;

    // Output side: the stall pattern switches at random between always
    // ready, mostly ready, a periodic low window, and mostly stalled.
    initial begin : rx_stall
        int hold;
        int mode;
        int phase;
        int low_len;
        int period;
        mix_if.ready = 1'b0;
        hold    = 0;
        mode    = 0;
        phase   = 0;
        low_len = 1;
        period  = 2;
        forever begin
            @(negedge clk);
            if (hold == 0) begin
                mode    = $urandom_range(0, 3);
                hold    = $urandom_range(30, 300);
                period  = $urandom_range(2, 16);
                low_len = $urandom_range(1, period - 1);
                phase   = 0;
            end
            hold = hold - 1;
            case (mode)
                0: mix_if.ready = 1'b1;
                1: mix_if.ready = ($urandom_range(0, 9) < 7);
                2: begin
                    mix_if.ready = (phase >= low_len);
                    phase = (phase + 1) % period;
                end
                default: mix_if.ready = ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            default: return t_sample'($urandom);
        endcase
    endfunction

    // All fields random, so that fields a request does not use still toggle.
    function automatic t_req rand_req();
        t_req r;
        r.req_type     = t_req_type'($urandom_range(0, 3));
        r.source_index = SRC_IN_W'($urandom);
        r.frame_addr   = ADDR_IN_W'($urandom);
        r.sample_left  = rand_sample();
        r.sample_right = rand_sample();
        r.clip_length  = LEN_IN_W'($urandom);
        r.loop_enable  = 1'($urandom);
        r.volume       = GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1));
        return r;
    endfunction

    // Presents one request and holds it until the transaction completes. Called and
    // returns at a falling edge. Valid stays high across a burst and drops for a gap.
    task automatic send_req(input t_req r);
        int s;
        req_if.valid = 1'b1;
        req_if.data  = r;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        items_sent = items_sent + 1;
        s = int'(r.source_index);
        case (r.req_type)
            REQ_WRITE: frame_written[s][int'(r.frame_addr)] = 1'b1;
            REQ_PLAY: begin
                plan_on[s]   = 1'b1;
                plan_pos[s]  = 0;
                plan_len[s]  = (int'(r.clip_length) > NFRM) ? NFRM : int'(r.clip_length);
                plan_loop[s] = r.loop_enable;
            end
            REQ_STOP: plan_on[s] = 1'b0;
            default: ;
        endcase
        @(negedge clk);
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic send_write(input int s, input int a, input t_sample l, input t_sample rt);
        t_req r;
        r = rand_req();
        r.req_type     = REQ_WRITE;
        r.source_index = SRC_IN_W'(s);
        r.frame_addr   = ADDR_IN_W'(a);
        r.sample_left  = l;
        r.sample_right = rt;
        send_req(r);
    endtask

    task automatic send_play(input int s, input int len, input bit lp, input int vol);
        t_req r;
        r = rand_req();
        r.req_type     = REQ_PLAY;
        r.source_index = SRC_IN_W'(s);
        r.clip_length  = LEN_IN_W'(len);
        r.loop_enable  = lp;
        r.volume       = GAIN_W'(vol);
        send_req(r);
    endtask

    task automatic send_stop(input int s);
        t_req r;
        r = rand_req();
        r.req_type     = REQ_STOP;
        r.source_index = SRC_IN_W'(s);
        send_req(r);
    endtask

    // Walks the planned playback state the way a mix will, writing any frame that is
    // about to be read but was never written, then sends the mix request itself.
    task automatic send_mix();
        t_req r;
        int   s;
        for (s = 0; s < NSRC; s++) begin
            if (!plan_on[s]) continue;
            if (plan_pos[s] >= plan_len[s]) begin
                if (plan_loop[s] && plan_len[s] != 0) begin
                    plan_pos[s] = 0;
                end else begin
                    plan_on[s] = 1'b0;
                    continue;
                end
            end
            if (!frame_written[s][plan_pos[s]]) begin
                send_write(s, plan_pos[s], rand_sample(), rand_sample());
            end
            plan_pos[s] = plan_pos[s] + 1;
        end
        r = rand_req();
        r.req_type = REQ_MIX;
        send_req(r);
    endtask

    // Holds the request channel idle until every predicted frame has come out.
    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (chk_pending != 0) @(negedge clk);
    endtask

    function automatic int rand_volume();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return int'(GAIN_UNITY);
            2: return $urandom_range(int'(GAIN_UNITY) + 1, (1 << GAIN_W) - 1);
            default: return $urandom_range(0, int'(GAIN_UNITY));
        endcase
    endfunction

    initial begin : stimulus
        int   pick;
        int   s;
        int   n;
        int   len;
        t_req r;
        req_if.valid = 1'b0;
        req_if.data  = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. A mix with nothing playing must give silence.
        send_mix();
        // Full-scale samples on two sources so that the sum saturates both ways.
        send_write(0, 0, SAMPLE_MAX, SAMPLE_MIN);
        send_write(0, 1, SAMPLE_MIN, SAMPLE_MAX);
        send_write(0, 2, 16'sd12345, -16'sd1);
        send_write(15, 0, SAMPLE_MAX, SAMPLE_MAX);
        send_write(15, 1, -16'sd1, SAMPLE_MIN);
        send_write(15, NFRM - 1, SAMPLE_MIN, 16'sd1);
        // Looping three-frame clip at unity, an oversized length and gain that both
        // saturate, and a zero-length looping clip that must stop on its own.
        send_play(0, 3, 1'b1, int'(GAIN_UNITY));
        send_play(15, MAX_LEN_IN, 1'b0, (1 << GAIN_W) - 1);
        send_play(1, 0, 1'b1, int'(GAIN_UNITY));
        repeat (4) send_mix();
        send_stop(15);
        // Zero gain, and the smallest nonzero gain, where every product truncates to zero.
        send_play(2, 1, 1'b0, 0);
        send_write(3, 0, SAMPLE_MIN, SAMPLE_MAX);
        send_play(3, NFRM, 1'b1, 1);
        repeat (2) send_mix();
        send_stop(0);
        send_stop(0);
        // Half gain on odd samples of both signs checks truncation toward zero.
        send_write(5, 0, -16'sd3, 16'sd3);
        send_play(5, 1, 1'b0, int'(GAIN_UNITY) / 2);
        repeat (2) send_mix();
        wait_drained();

        // Random part: mostly clip loads followed by play and mix runs, plus noise.
        while (items_sent < 900) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                s = $urandom_range(0, NSRC - 1);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
                for (int a = 0; a < n; a++) send_write(s, a, rand_sample(), rand_sample());
                case ($urandom_range(0, 19))
                    0: len = 0;
                    1: len = $urandom_range(NFRM + 1, MAX_LEN_IN);
                    2: len = n + $urandom_range(1, 8);
                    default: len = n;
                endcase
                send_play(s, len, 1'($urandom), rand_volume());
            end else if (pick < 72) begin
                repeat ($urandom_range(1, 8)) send_mix();
            end else if (pick < 80) begin
                send_stop($urandom_range(0, NSRC - 1));
            end else if (pick < 87) begin
                send_write($urandom_range(0, NSRC - 1), $urandom_range(0, NFRM - 1),
                           rand_sample(), rand_sample());
            end else if (pick < 93) begin
                send_play($urandom_range(0, NSRC - 1), $urandom_range(0, MAX_LEN_IN),
                          1'($urandom), rand_volume());
            end else if (pick < 95) begin
                wait_drained();
            end else begin
                r = rand_req();
                if (r.req_type == REQ_MIX) send_mix();
                else send_req(r);
            end
        end

        // Drain, then wait for longer than a mix takes, to catch anything stray.
        wait_drained();
        repeat (2 * (NSRC + 5)) @(negedge clk);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/msam_pkg.sv
rtl/msam_stream_if.sv
rtl/msam_clip_mem.sv
rtl/msam_src_mem.sv
rtl/msam_mix_dp.sv
rtl/multi_source_audio_mixer.sv
sim/msam_mix_checker.sv
sim/tb.sv
